>>> rtl/sector_interleave_mapper_unit_defines.svh
// assertion macros for the sector interleave mapper
// used by the rtl files that carry concurrent checks, no other dependencies
`ifndef SECTOR_INTERLEAVE_MAPPER_UNIT_DEFINES_SVH
`define SECTOR_INTERLEAVE_MAPPER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SIM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sim check failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define SIM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sim check failed: next-cycle implication");

`endif

>>> rtl/sim_pkg.sv
// shared constants and types for the sector interleave mapper
// no dependencies, imported by sector_interleave_mapper_unit, sim_mod_add and the testbench
`default_nettype none

package sim_pkg;

   localparam int TOTAL_SLOTS = 2880;
   localparam int SLOT_W      = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
   localparam int SECTOR_W    = 12;
   localparam int GAP_W       = 12;
   localparam int RESULT_W    = 12;
   // holds the raw gap and any value below TOTAL_SLOTS
   localparam int REM_W       = (SLOT_W + 1 > GAP_W) ? SLOT_W + 1 : GAP_W;

   typedef logic [SLOT_W-1:0]   slot_type;
   typedef logic [SECTOR_W-1:0] sector_type;
   typedef logic [GAP_W-1:0]    gap_type;
   typedef logic [RESULT_W-1:0] result_type;
   typedef logic [REM_W-1:0]    rem_type;

endpackage

`default_nettype wire

>>> rtl/sector_interleave_mapper_unit.sv
// top level of the sector interleave mapper: sequencer, occupancy map, result register
// depends on sim_pkg, sim_ram, sim_mod_add and sector_interleave_mapper_unit_defines.svh
//
//   channel   ports                                   direction  handshake
//   request   start, busy, req_logical_sector         in         start & !busy
//   response  rsp_strobe, rsp_physical_slot,          out        one-cycle strobe
//             rsp_valid_res
//   config    csr_wr_en, csr_wr_data                  in         write when csr_wr_en
//
// a sector beyond the disk or a zero gap answers in the next cycle, busy stays low
// otherwise: gap reduction by repeated subtraction, a clear of all TOTAL_SLOTS map
// entries, then a read state and a check state per probed slot through the single map port,
// up to one probe per placed sector plus one per occupied slot skipped
// busy is high for the whole walk, the response strobe follows the last probe
// sync active-high reset, each walk clears the map itself; responses never stall
`default_nettype none

module sector_interleave_mapper_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire sim_pkg::sector_type req_logical_sector,
   output logic                     rsp_strobe,
   output sim_pkg::result_type      rsp_physical_slot,
   output logic                     rsp_valid_res,
   input  wire logic                csr_wr_en,
   input  wire sim_pkg::gap_type    csr_wr_data
);
   import sim_pkg::*;

`include "sector_interleave_mapper_unit_defines.svh"

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_STEP  = 3'd1;
   localparam logic [2:0] ST_CLEAR = 3'd2;
   localparam logic [2:0] ST_READ  = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;

   logic [2:0] state_ff, state_in;
   gap_type    gap_ff, gap_in;
   sector_type sector_ff, sector_in;
   sector_type idx_ff, idx_in;
   rem_type    rem_ff, rem_in;
   slot_type   step_ff, step_in;
   slot_type   cnt_ff, cnt_in;
   slot_type   pos_ff, pos_in;
   logic       strobe_ff, strobe_in;
   result_type slot_out_ff, slot_out_in;
   logic       ok_ff, ok_in;

   // shared adder operands
   slot_type op_a, op_b, op_sum;

   // map port
   logic     map_wr_en;
   slot_type map_wr_addr;
   logic     map_wr_data;
   logic     map_rd_data;

   logic accept;
   logic in_range;

   assign accept   = start && !busy;
   assign in_range = 32'(req_logical_sector) < TOTAL_SLOTS;

   sim_mod_add u_add (
      .a   (op_a),
      .b   (op_b),
      .sum (op_sum)
   );

   sim_ram #(
      .WIDTH (1),
      .DEPTH (TOTAL_SLOTS)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_wr_en),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (pos_ff),
      .rd_data (map_rd_data)
   );

   // operand select for the shared adder
   always_comb begin
      case (state_ff)
         ST_STEP: begin
            op_a = rem_ff[SLOT_W-1:0];
            op_b = slot_type'(1);
         end
         ST_CLEAR: begin
            op_a = cnt_ff;
            op_b = slot_type'(1);
         end
         ST_CHECK: begin
            op_a = pos_ff;
            // occupied slot: probe the next one, else jump by the step
            op_b = map_rd_data ? slot_type'(1) : step_ff;
         end
         default: begin
            op_a = pos_ff;
            op_b = slot_type'(1);
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      gap_in      = gap_ff;
      sector_in   = sector_ff;
      idx_in      = idx_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      cnt_in      = cnt_ff;
      pos_in      = pos_ff;
      strobe_in   = 1'b0;
      slot_out_in = slot_out_ff;
      ok_in       = ok_ff;
      map_wr_en   = 1'b0;
      map_wr_addr = pos_ff;
      map_wr_data = 1'b1;

      if (csr_wr_en) begin
         gap_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!in_range) begin
                  strobe_in   = 1'b1;
                  slot_out_in = '0;
                  ok_in       = 1'b0;
               end else if (gap_ff == '0) begin
                  // no interleave, identity mapping
                  strobe_in   = 1'b1;
                  slot_out_in = result_type'(req_logical_sector);
                  ok_in       = 1'b1;
               end else begin
                  sector_in = req_logical_sector;
                  rem_in    = rem_type'(gap_ff);
                  state_in  = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            // gap mod TOTAL_SLOTS by repeated subtraction, then step = (rem + 1) wrapped
            if (rem_ff >= rem_type'(TOTAL_SLOTS)) begin
               rem_in = rem_ff - rem_type'(TOTAL_SLOTS);
            end else begin
               step_in  = op_sum;
               cnt_in   = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            map_wr_en   = 1'b1;
            map_wr_addr = cnt_ff;
            map_wr_data = 1'b0;
            if (cnt_ff == slot_type'(TOTAL_SLOTS - 1)) begin
               pos_in   = '0;
               idx_in   = '0;
               state_in = ST_READ;
            end else begin
               cnt_in = op_sum;
            end
         end
         ST_READ: begin
            // map read of pos_ff lands next cycle
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (map_rd_data) begin
               pos_in   = op_sum;
               state_in = ST_READ;
            end else begin
               map_wr_en   = 1'b1;
               map_wr_addr = pos_ff;
               map_wr_data = 1'b1;
               if (idx_ff == sector_ff) begin
                  strobe_in   = 1'b1;
                  slot_out_in = result_type'(pos_ff);
                  ok_in       = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  pos_in   = op_sum;
                  idx_in   = idx_ff + sector_type'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         gap_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         gap_ff    <= gap_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sector_ff   <= sector_in;
      idx_ff      <= idx_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      cnt_ff      <= cnt_in;
      pos_ff      <= pos_in;
      slot_out_ff <= slot_out_in;
      ok_ff       <= ok_in;
   end

   assign busy              = state_ff != ST_IDLE;
   assign rsp_strobe        = strobe_ff;
   assign rsp_physical_slot = slot_out_ff;
   assign rsp_valid_res     = ok_ff;

   // an out-of-range response always carries slot zero
   `SIM_ASSERT_IMPLY(a_invalid_zero, clock, reset, strobe_ff && !ok_ff, slot_out_ff == '0)
   // an accepted request either answers at once or starts the walk
   `SIM_ASSERT_NEXT(a_accept_acts, clock, reset, accept, busy || strobe_ff)
   // every map check follows its read
   `SIM_ASSERT_NEXT(a_read_then_check, clock, reset, state_ff == ST_READ, state_ff == ST_CHECK)
   // the probe position stays inside the disk
   `SIM_ASSERT_IMPLY(a_pos_range, clock, reset, state_ff == ST_READ || state_ff == ST_CHECK, 32'(pos_ff) < TOTAL_SLOTS)

endmodule

`default_nettype wire

>>> rtl/sim_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module sim_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/sim_mod_add.sv
// shared modular adder: (a + b) wrapped into 0..TOTAL_SLOTS-1
// depends on sim_pkg, operands must already be below TOTAL_SLOTS
`default_nettype none

module sim_mod_add (
   input  wire sim_pkg::slot_type a,
   input  wire sim_pkg::slot_type b,
   output sim_pkg::slot_type      sum
);
   import sim_pkg::*;

   logic [SLOT_W:0] raw;

   always_comb begin
      raw = {1'b0, a} + {1'b0, b};
      if (raw >= (SLOT_W + 1)'(TOTAL_SLOTS)) begin
         raw = raw - (SLOT_W + 1)'(TOTAL_SLOTS);
      end
      sum = raw[SLOT_W-1:0];
   end

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for sector_interleave_mapper_unit
// depends on sim_pkg and the block rtl; predicts every slot, with its own occupancy walk for a nonzero gap

module testbench;
   import sim_pkg::*;

   typedef struct {
      result_type slot;
      logic       in_range;
   } slot_answer_type;

   // keeps its own copy of the gap and the map, holds the slots still owed
   class slot_map_checker;
      gap_type         gap;
      bit              taken[TOTAL_SLOTS];
      slot_answer_type owed[$];
      int unsigned     errors;

      function new();
         gap    = '0;
         errors = 0;
      endfunction

      // lays out sectors 0..target under the current gap, returns the slot of target
      function result_type walk_map(input int unsigned target, output int unsigned probes);
         int unsigned step;
         int unsigned pos;
         int unsigned tries;
         step   = (int'(gap) % TOTAL_SLOTS + 1) % TOTAL_SLOTS;
         pos    = 0;
         probes = 0;
         foreach (taken[k]) taken[k] = 1'b0;
         for (int unsigned i = 0; i <= target; i++) begin
            tries = 0;
            probes++;
            // first free slot at or after pos, bounded search
            while (taken[pos] && tries < TOTAL_SLOTS) begin
               pos = (pos + 1) % TOTAL_SLOTS;
               tries++;
               probes++;
            end
            taken[pos] = 1'b1;
            if (i == target) break;
            pos = (pos + step) % TOTAL_SLOTS;
         end
         return result_type'(pos);
      endfunction

      // queues the expected response, returns a cycle estimate for the request
      function int unsigned note_request(sector_type sector);
         slot_answer_type ans;
         int unsigned     probes;
         int unsigned     cost;
         cost = 2;
         if (int'(sector) >= TOTAL_SLOTS) begin
            ans.slot     = '0;
            ans.in_range = 1'b0;
         end else if (gap == '0) begin
            ans.slot     = result_type'(sector);
            ans.in_range = 1'b1;
         end else begin
            ans.slot     = walk_map(sector, probes);
            ans.in_range = 1'b1;
            cost = int'(gap) / TOTAL_SLOTS + 1 + TOTAL_SLOTS + 2 * probes + 4;
         end
         owed.push_back(ans);
         return cost;
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("mismatch: %s", what);
      endfunction

      function void check_response(result_type slot, logic in_range);
         slot_answer_type want;
         if (owed.size() == 0) begin
            flag($sformatf("response with no request pending, slot %0d valid %0b",
                           slot, in_range));
            return;
         end
         want = owed.pop_front();
         if (slot !== want.slot)
            flag($sformatf("physical_slot expected %0d, got %0d", want.slot, slot));
         if (in_range !== want.in_range)
            flag($sformatf("valid_res expected %0b, got %0b", want.in_range, in_range));
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   sector_type req_logical_sector = '0;
   logic       rsp_strobe;
   result_type rsp_physical_slot;
   logic       rsp_valid_res;
   logic       csr_wr_en = 1'b0;
   gap_type    csr_wr_data = '0;

   slot_map_checker board = new();

   // sender idle limit for the current stretch, zero means back to back
   int unsigned     idle_max = 0;
   longint unsigned cycle_count = 0;
   // grows with every accepted request by a multiple of its expected walk time
   longint unsigned cycle_limit = 4000;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sector_interleave_mapper_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_logical_sector (req_logical_sector),
      .rsp_strobe         (rsp_strobe),
      .rsp_physical_slot  (rsp_physical_slot),
      .rsp_valid_res      (rsp_valid_res),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // watchdog on a hung walk or a missing response
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   // responses cannot be held off, so every strobe is checked on its edge
   always @(posedge clock) begin
      if (!reset && rsp_strobe) board.check_response(rsp_physical_slot, rsp_valid_res);
   end

   // start stays high when the next request follows at once
   task automatic send_request(input sector_type sector);
      int unsigned idle;
      idle = $urandom_range(0, idle_max);
      if (idle != 0) begin
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      start <= 1'b1;
      req_logical_sector <= sector;
      do @(posedge clock); while (busy);
      cycle_limit += 4 * (board.note_request(sector) + 16);
   endtask

   // lets every owed response arrive so the gap can change safely
   task automatic drain();
      start <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      cycle_limit += 64;
   endtask

   task automatic write_gap(input gap_type value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.gap = value;
   endtask

   // a few out-of-disk numbers, tiny sectors when the step is zero, else short walks or any sector on the disk
   function automatic sector_type pick_sector(gap_type gap);
      int unsigned roll;
      roll = $urandom_range(0, 15);
      if (roll < 2) return sector_type'($urandom_range(TOTAL_SLOTS, 4095));
      if (gap == gap_type'(TOTAL_SLOTS - 1)) return sector_type'($urandom_range(0, 200));
      if (roll < 6) return sector_type'($urandom_range(0, 63));
      return sector_type'($urandom_range(0, TOTAL_SLOTS - 1));
   endfunction

   function automatic gap_type pick_gap();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return gap_type'(TOTAL_SLOTS - 1);
         2: return gap_type'($urandom_range(TOTAL_SLOTS, 4095));
         3: return gap_type'($urandom_range(1, 7));
         default: return gap_type'($urandom_range(1, TOTAL_SLOTS - 1));
      endcase
   endfunction

   initial begin
      sector_type  list[$];
      gap_type     gap;
      int unsigned left;
      int unsigned burst;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // gap from reset is zero: identity map, disk edges, numbers past the disk
      idle_max = 7;
      list = '{12'd0, 12'd4095, 12'd2880, 12'd2879, 12'd2048};
      foreach (list[k]) send_request(list[k]);
      drain();

      // smallest gap, first and second lap of the map, back to back
      idle_max = 0;
      write_gap(12'd1);
      list = '{12'd0, 12'd1, 12'd2, 12'd1439, 12'd1440, 12'd2879, 12'd3000};
      foreach (list[k]) send_request(list[k]);
      drain();

      // gap of TOTAL_SLOTS - 1: step wraps to zero, every placement searches forward
      idle_max = 7;
      write_gap(gap_type'(TOTAL_SLOTS - 1));
      list = '{12'd0, 12'd1, 12'd2, 12'd5, 12'd150};
      foreach (list[k]) send_request(list[k]);
      drain();

      // gap beyond the disk size, advance taken modulo the slot count
      write_gap(12'd4095);
      list = '{12'd2879, 12'd7, 12'd4095};
      foreach (list[k]) send_request(list[k]);
      drain();

      // explicit write of zero back to the identity map, alternating bit patterns
      idle_max = 0;
      write_gap(12'd0);
      list = '{12'h555, 12'haaa, 12'd1};
      foreach (list[k]) send_request(list[k]);
      drain();

      // random phases: new gap, a burst of requests, then drain
      left = 80;
      while (left != 0) begin
         gap = pick_gap();
         write_gap(gap);
         idle_max = ($urandom_range(0, 2) == 0) ? 0 : 7;
         burst = $urandom_range(5, 15);
         if (burst > left) burst = left;
         repeat (burst) send_request(pick_sector(gap));
         drain();
         left -= burst;
      end

      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
